### rtl/tlbsa_pkg.sv
// shared constants, status codes and helpers of the two-level bitmap slot allocator
package tlbsa_pkg;

    localparam int NUM_SLOTS   = 64;
    localparam int GROUP_BITS  = 8;
    localparam int GROUP_SHIFT = 3;
    localparam int NUM_GROUPS  = 8;

    localparam int SLOT_W  = 6;
    localparam int GROUP_W = 3;
    localparam int FREE_W  = 7;
    localparam int BASE_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 33;
    localparam int PROD_W  = SIZE_W + SLOT_W;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int ID_W    = 8;

    localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ID       = 2'd2;
    localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_BUFFER_BASE = 1'b0;
    localparam logic CFG_BUFFER_SIZE = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 17'd4096;

    typedef logic [GROUP_BITS-1:0] t_mask;

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [GROUP_W-1:0] low_bit(input t_mask v);
        logic [GROUP_W-1:0] idx;
        idx = '0;
        for (int i = GROUP_BITS - 1; i >= 0; i--) begin
            if (v[i]) idx = GROUP_W'(i);
        end
        return idx;
    endfunction

    // reset mask of one group: bits of slots below NUM_SLOTS
    function automatic t_mask reset_mask(input int g);
        t_mask m;
        m = '0;
        for (int b = 0; b < GROUP_BITS; b++) begin
            if (g * GROUP_BITS + b < NUM_SLOTS) m[b] = 1'b1;
        end
        return m;
    endfunction

endpackage

### rtl/two_level_bitmap_slot_allocator.sv
// top level of the two-level bitmap slot allocator: masks, sequencer and shift-add address unit
// sequence: a free or double free is decoded, its address formed in the shared shift-add unit and then
// loaded as its transfer; no space or bad id goes from decode straight to the output register; an
// allocation runs a lookup, the shift-add unit and an output step for each slot that it grants
// flow: one request at a time; a new request is taken once the last result is registered,
// a stalled result holds the sequencer, and a zero count is dropped without a result
// reset: synchronous active low, all slots below NUM_SLOTS free, buffer_size 4096, base 0
module two_level_bitmap_slot_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // count[6:0], slot_id[14:7], zero pad
    input  logic        s_axis_tuser,   // op
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // granted_slot[5:0], slot_address[38:6], slot_bytes[55:39]
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,   // last result of the request
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // sequencer codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_FIND   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    localparam logic [2:0] MUL_LAST = 3'(tlbsa_pkg::SLOT_W - 1);

    // configuration registers
    logic [tlbsa_pkg::BASE_W-1:0] r_base;
    logic [tlbsa_pkg::SIZE_W-1:0] r_size;

    // allocator state
    tlbsa_pkg::t_mask             r_slot_masks [tlbsa_pkg::NUM_GROUPS];
    tlbsa_pkg::t_mask             r_group_mask;
    logic [tlbsa_pkg::FREE_W-1:0] r_free_count;

    // request and sequencer registers
    logic [2:0]                    r_state;
    logic                          r_op;
    logic [tlbsa_pkg::COUNT_W-1:0] r_remain;
    logic [tlbsa_pkg::ID_W-1:0]    r_id;
    logic [tlbsa_pkg::SLOT_W-1:0]  r_slot;
    logic [tlbsa_pkg::STAT_W-1:0]  r_status;
    logic                          r_last;
    logic                          r_addr_ok;
    logic [tlbsa_pkg::PROD_W-1:0]  r_acc;
    logic [2:0]                    r_mbit;

    // output register
    logic                          r_out_valid;
    logic [tlbsa_pkg::STAT_W-1:0]  r_out_status;
    logic [tlbsa_pkg::SLOT_W-1:0]  r_out_slot;
    logic [tlbsa_pkg::ADDR_W-1:0]  r_out_addr;
    logic [tlbsa_pkg::SIZE_W-1:0]  r_out_bytes;
    logic                          r_out_last;

    // single read port on the slot masks, group chosen by the sequencer
    logic [tlbsa_pkg::GROUP_W-1:0] rd_group;
    tlbsa_pkg::t_mask              rd_mask;
    logic [tlbsa_pkg::GROUP_W-1:0] low_slot;
    tlbsa_pkg::t_mask              clr_mask;

    logic                          in_fire;
    logic                          out_free;
    logic [tlbsa_pkg::PROD_W-1:0]  addend;
    logic [tlbsa_pkg::ADDR_W-1:0]  emit_addr;
    tlbsa_pkg::t_mask              occupied_groups;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign rd_group = (r_state == S_FIND) ? tlbsa_pkg::low_bit(r_group_mask)
                                          : r_id[tlbsa_pkg::SLOT_W-1:tlbsa_pkg::GROUP_SHIFT];
    assign rd_mask  = r_slot_masks[rd_group];
    assign low_slot = tlbsa_pkg::low_bit(rd_mask);
    assign clr_mask = rd_mask & ~(tlbsa_pkg::t_mask'(1) << low_slot);

    // shared shift-add unit: one multiplier bit of the slot number per cycle
    assign addend    = r_slot[r_mbit] ? (tlbsa_pkg::PROD_W'(r_size) << r_mbit) : '0;
    assign emit_addr = tlbsa_pkg::ADDR_W'(r_base) + tlbsa_pkg::ADDR_W'(r_acc);

    always_comb begin
        for (int g = 0; g < tlbsa_pkg::NUM_GROUPS; g++) begin
            occupied_groups[g] = |r_slot_masks[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_size       <= tlbsa_pkg::SIZE_RESET;
            for (int g = 0; g < tlbsa_pkg::NUM_GROUPS; g++) begin
                r_slot_masks[g] <= tlbsa_pkg::reset_mask(g);
                r_group_mask[g] <= |tlbsa_pkg::reset_mask(g);
            end
            r_free_count <= tlbsa_pkg::FREE_W'(tlbsa_pkg::NUM_SLOTS);
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration transfers, to be issued only while the block is idle; the block itself does not enforce it
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tlbsa_pkg::CFG_BUFFER_BASE: r_base <= i_cfg_data;
                    tlbsa_pkg::CFG_BUFFER_SIZE: r_size <= i_cfg_data[tlbsa_pkg::SIZE_W-1:0];
                    default: ;
                endcase
            end

            // a taken transfer empties the output register unless the emit step refills it
            if (m_axis_tvalid && m_axis_tready && (r_state != S_EMIT)) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_op     <= s_axis_tuser;
                        r_remain <= s_axis_tdata[6:0];
                        r_id     <= s_axis_tdata[14:7];
                        r_state  <= S_DECODE;
                    end
                end

                S_DECODE: begin
                    r_last <= 1'b1;
                    r_acc  <= '0;
                    r_mbit <= '0;
                    if (r_op == tlbsa_pkg::OP_ALLOC) begin
                        if (r_remain == '0) begin
                            // empty request: nothing to report
                            r_state <= S_IDLE;
                        end else if (r_remain > r_free_count) begin
                            r_status  <= tlbsa_pkg::ST_NO_SPACE;
                            r_slot    <= '0;
                            r_addr_ok <= 1'b0;
                            r_state   <= S_EMIT;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end else begin
                        if (r_id >= tlbsa_pkg::ID_W'(tlbsa_pkg::NUM_SLOTS)) begin
                            r_status  <= tlbsa_pkg::ST_BAD_ID;
                            r_slot    <= '0;
                            r_addr_ok <= 1'b0;
                            r_state   <= S_EMIT;
                        end else if (rd_mask[r_id[tlbsa_pkg::GROUP_SHIFT-1:0]]) begin
                            // double free: reported, not counted
                            r_slot    <= r_id[tlbsa_pkg::SLOT_W-1:0];
                            r_status  <= tlbsa_pkg::ST_ALREADY_FREE;
                            r_addr_ok <= 1'b1;
                            r_state   <= S_MUL;
                        end else begin
                            r_slot_masks[rd_group] <= rd_mask |
                                (tlbsa_pkg::t_mask'(1) << r_id[tlbsa_pkg::GROUP_SHIFT-1:0]);
                            r_group_mask[rd_group] <= 1'b1;
                            r_free_count <= r_free_count + 1'b1;
                            r_slot       <= r_id[tlbsa_pkg::SLOT_W-1:0];
                            r_status     <= tlbsa_pkg::ST_OK;
                            r_addr_ok    <= 1'b1;
                            r_state      <= S_MUL;
                        end
                    end
                end

                S_FIND: begin
                    // lowest set group, then lowest free slot in it
                    r_slot                 <= {rd_group, low_slot};
                    r_slot_masks[rd_group] <= clr_mask;
                    if (clr_mask == '0) r_group_mask[rd_group] <= 1'b0;
                    r_free_count <= r_free_count - 1'b1;
                    r_remain     <= r_remain - 1'b1;
                    r_last       <= (r_remain == tlbsa_pkg::COUNT_W'(1));
                    r_status     <= tlbsa_pkg::ST_OK;
                    r_addr_ok    <= 1'b1;
                    r_acc        <= '0;
                    r_mbit       <= '0;
                    r_state      <= S_MUL;
                end

                S_MUL: begin
                    r_acc  <= r_acc + addend;
                    r_mbit <= r_mbit + 1'b1;
                    if (r_mbit == MUL_LAST) r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_slot   <= r_slot;
                        r_out_addr   <= r_addr_ok ? emit_addr : '0;
                        r_out_bytes  <= r_addr_ok ? r_size : '0;
                        r_out_last   <= r_last;
                        r_state      <= r_last ? S_IDLE : S_FIND;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {r_out_bytes, r_out_addr, r_out_slot};

    // free count tracks the number of set slot bits
    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count == tlbsa_pkg::FREE_W'($countones({r_slot_masks[7], r_slot_masks[6],
            r_slot_masks[5], r_slot_masks[4], r_slot_masks[3], r_slot_masks[2],
            r_slot_masks[1], r_slot_masks[0]})))
        else $error("free count out of step with slot masks");

    // a group bit is set exactly when its group still holds a free slot
    a_group_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_group_mask == occupied_groups)
        else $error("group mask out of step with slot masks");

    // a rejected request always ends in a single transfer
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == tlbsa_pkg::ST_NO_SPACE ||
                          m_axis_tuser == tlbsa_pkg::ST_BAD_ID) |-> m_axis_tlast)
        else $error("rejected request without last flag");

endmodule
